// ----- rtl/core/tabx_pkg.sv -----
package tabx_pkg;

	localparam int CHAR_W     = 8;
	localparam int COL_W      = 6;
	localparam int CNT_W      = 3;
	localparam int IV_W       = 4;
	localparam int NUM_STOPS  = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 6;
	localparam int QDEPTH     = 4;

	localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

	localparam logic [IV_W-1:0] FALLBACK_INTERVAL = 4'd8;

	localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_INTERVAL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_A           = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_B           = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_C           = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_D           = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_E           = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_F           = 3'd7;

	typedef struct packed {
		logic [CNT_W-1:0]                 stop_count;
		logic [IV_W-1:0]                  interval;
		logic [NUM_STOPS-1:0][COL_W-1:0]  stops;
	} cfg_t;

	// one queued run: the byte to emit and how many times
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic [COL_W-1:0]  cnt;
	} q_entry_t;

endpackage

// ----- rtl/core/tabx_queue.sv -----
module tabx_queue import tabx_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  q_entry_t push_data,
	output logic     pop_valid,
	input  logic     pop_ready,
	output q_entry_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	q_entry_t          mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (fill_q != FILL_W'(DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/tabx_front.sv -----
module tabx_front import tabx_pkg::*; #(
	parameter int MAX_STOPS    = 6,
	parameter int LINE_COLUMNS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CHAR_W-1:0] in_char,
	output logic              push_valid,
	input  logic              push_ready,
	output q_entry_t          push_data
);

	localparam logic [COL_W-1:0] LAST_COL  = COL_W'(LINE_COLUMNS - 1);
	localparam logic [CNT_W-1:0] STOP_LIM  = CNT_W'(MAX_STOPS);
	localparam logic [2:0]       LAST_STEP = 3'(COL_W - 1);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_DIV  = 2'd1;
	localparam logic [1:0] F_PUSH = 2'd2;

	logic [1:0]       state_q;
	logic [COL_W-1:0] column_q;
	logic [IV_W-1:0]  rem_q;
	logic [2:0]       step_q;

	logic             accept;
	logic             is_tab;
	logic [IV_W-1:0]  iv;
	logic [CNT_W-1:0] n_eff;
	logic [IV_W:0]    trial;
	logic             found;
	logic [COL_W-1:0] best;
	logic [COL_W:0]   dflt_tgt;
	logic [COL_W:0]   raw_tgt;
	logic [COL_W-1:0] target;
	logic [COL_W-1:0] tab_cnt;

	assign is_tab = (in_char == CH_TAB);
	assign iv     = (cfg.interval == '0) ? FALLBACK_INTERVAL : cfg.interval;
	assign n_eff  = (cfg.stop_count > STOP_LIM) ? STOP_LIM : cfg.stop_count;

	assign in_ready = (state_q == F_IDLE) && push_ready;
	assign accept   = in_valid && in_ready;

	// one remainder bit per cycle, most significant column bit first
	assign trial = {rem_q, column_q[3'(LAST_STEP - step_q)]};

	always_comb begin
		found = 1'b0;
		best  = '0;
		for (int i = 0; i < NUM_STOPS; i++) begin
			if ((CNT_W'(i) < n_eff) && (cfg.stops[i] > column_q)
					&& (!found || cfg.stops[i] < best)) begin
				found = 1'b1;
				best  = cfg.stops[i];
			end
		end
	end

	assign dflt_tgt = {1'b0, column_q} - {3'b000, rem_q} + {3'b000, iv};
	assign raw_tgt  = found ? {1'b0, best} : dflt_tgt;
	assign target   = (raw_tgt > {1'b0, LAST_COL}) ? LAST_COL : raw_tgt[COL_W-1:0];
	assign tab_cnt  = (target > column_q) ? target - column_q : COL_W'(1);

	always_comb begin
		push_valid = 1'b0;
		push_data  = '{ch: in_char, cnt: COL_W'(1)};
		unique case (state_q)
			F_IDLE: begin
				push_valid = in_valid && !is_tab;
			end
			F_PUSH: begin
				push_valid = 1'b1;
				push_data  = '{ch: CH_SPACE, cnt: tab_cnt};
			end
			default: begin
				push_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && is_tab) begin
			rem_q  <= '0;
			step_q <= '0;
		end else if (state_q == F_DIV) begin
			rem_q  <= (trial >= {1'b0, iv}) ? IV_W'(trial - {1'b0, iv}) : trial[IV_W-1:0];
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			column_q <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (is_tab) begin
							state_q <= F_DIV;
						end else if (in_char == CH_NL) begin
							column_q <= '0;
						end else if (column_q < LAST_COL) begin
							column_q <= column_q + 1'b1;
						end
					end
				end
				F_DIV: begin
					if (step_q == LAST_STEP) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (push_ready) begin
						// saturated at the last column when the target does not move
						if (target > column_q) begin
							column_q <= target;
						end
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/tabx_back.sv -----
module tabx_back import tabx_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  q_entry_t          pop_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAR_W-1:0] out_char,
	output logic              last_of_run
);

	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              last_q;
	logic [COL_W-1:0]  done_q;
	logic              load;
	logic              run_end;

	assign load      = pop_valid && (!out_valid_q || out_ready);
	assign run_end   = (done_q == pop_data.cnt - 1'b1);
	assign pop_ready = load && run_end;

	assign out_valid   = out_valid_q;
	assign out_char    = out_char_q;
	assign last_of_run = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q <= pop_data.ch;
			last_q     <= run_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			done_q      <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				done_q      <= run_end ? '0 : done_q + 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/core/tab_expand_with_stop_list.sv -----
// Tab expander with a list of up to six tab stops. Bytes enter on the in_*
// channel; a tab leaves as one or more spaces (last_of_run on the final one)
// that move the column to the nearest listed stop beyond it, or else to the
// next multiple of default_interval, clamped at the last column; a newline
// resets the column; any other byte passes and advances it. A tab holds the
// input while a bit-serial remainder unit finds the default stop, one column
// bit per cycle; the output side then emits one space per cycle while
// out_ready is high, overlapped with later input through a four-entry queue.
// Write the cfg_* registers only while idle.
module tab_expand_with_stop_list import tabx_pkg::*; #(
	parameter int MAX_STOPS    = 6,
	parameter int LINE_COLUMNS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CHAR_W-1:0]     in_char,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CHAR_W-1:0]     out_char,
	output logic                  last_of_run
);

	cfg_t     cfg_q;
	logic     push_valid;
	logic     push_ready;
	q_entry_t push_data;
	logic     pop_valid;
	logic     pop_ready;
	q_entry_t pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stop_count <= '0;
			cfg_q.interval   <= FALLBACK_INTERVAL;
			cfg_q.stops      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index) inside
				REG_STOP_COUNT: begin
					cfg_q.stop_count <= cfg_data[CNT_W-1:0];
				end
				REG_DEFAULT_INTERVAL: begin
					cfg_q.interval <= cfg_data[IV_W-1:0];
				end
				REG_STOP_A, REG_STOP_B, REG_STOP_C, REG_STOP_D, REG_STOP_E, REG_STOP_F: begin
					cfg_q.stops[CFG_IDX_W'(cfg_index - REG_STOP_A)] <= cfg_data[COL_W-1:0];
				end
				default: begin
					cfg_q.stop_count <= cfg_q.stop_count;
				end
			endcase
		end
	end

	tabx_front #(
		.MAX_STOPS    (MAX_STOPS),
		.LINE_COLUMNS (LINE_COLUMNS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_char    (in_char),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	tabx_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	tabx_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_data    (pop_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.last_of_run (last_of_run)
	);

endmodule

// ----- rtl/core/tabx_checker.sv -----
module tabx_checker import tabx_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [CHAR_W-1:0] in_char,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CHAR_W-1:0] out_char,
	input logic              last_of_run
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last_of_run))
		else $error("stalled result changed");

	// only expansion spaces can be followed by more results of the same run
	a_mid_run_space: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> out_char == CH_SPACE)
		else $error("non-final result is not a space");

	// an unfinished run continues in the very next cycle
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid && out_char == CH_SPACE)
		else $error("tab run stalled or broken");

	// once a tab is taken, the input side is blocked while the tab expands
	a_tab_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_char == CH_TAB |=> !in_ready)
		else $error("input taken during tab expansion");

endmodule

bind tab_expand_with_stop_list tabx_checker u_tabx_checker (.*);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import tabx_pkg::*;

	localparam int MAX_STOPS      = 6;
	localparam int LINE_COLUMNS   = 64;
	localparam int LAST_COL       = LINE_COLUMNS - 1;
	localparam int SETTLE_CYCLES  = 20;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS    = 70;

	// Predicts the expanded byte stream and matches it against the output channel.
	class detab_scoreboard;
		typedef struct {
			logic [CHAR_W-1:0] ch;
			logic              last;
		} beat_t;

		beat_t            expected_beats[$];
		logic [CNT_W-1:0] stop_count;
		logic [IV_W-1:0]  interval;
		logic [COL_W-1:0] stops[NUM_STOPS];
		int               column;
		int               errors;

		function new();
			stop_count = '0;
			interval = FALLBACK_INTERVAL;
			foreach (stops[i])
				stops[i] = '0;
			column = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_STOP_COUNT: begin
				stop_count = data[CNT_W-1:0];
			end
			REG_DEFAULT_INTERVAL: begin
				interval = data[IV_W-1:0];
			end
			default: begin
				stops[idx - REG_STOP_A] = data;
			end
			endcase
		endfunction

		function int tab_stop_after(int col);
			int  n;
			int  best;
			int  iv;
			bit  found;
			n = (stop_count > MAX_STOPS) ? MAX_STOPS : stop_count;
			best = 0;
			found = 1'b0;
			for (int i = 0; i < n; i++) begin
				if (stops[i] > col && (!found || stops[i] < best)) begin
					best = stops[i];
					found = 1'b1;
				end
			end
			if (!found) begin
				iv = (interval == 0) ? FALLBACK_INTERVAL : interval;
				best = (col / iv + 1) * iv;
			end
			if (best > LAST_COL)
				best = LAST_COL;
			return best;
		endfunction

		function void note_char(logic [CHAR_W-1:0] c);
			int target;
			int count;
			if (c == CH_TAB) begin
				target = tab_stop_after(column);
				count = (target > column) ? target - column : 1;
				for (int k = 0; k < count; k++)
					expected_beats.push_back('{CH_SPACE, k == count - 1});
				column = column + count;
				if (column > LAST_COL)
					column = LAST_COL;
			end else if (c == CH_NL) begin
				expected_beats.push_back('{c, 1'b1});
				column = 0;
			end else begin
				expected_beats.push_back('{c, 1'b1});
				if (column < LAST_COL)
					column++;
			end
		endfunction

		function void check_beat(logic [CHAR_W-1:0] ch, logic last);
			beat_t want;
			if (expected_beats.size() == 0) begin
				$display("%0t: unexpected output: expected none, actual char %02h last %0b",
					$time, ch, last);
				errors++;
				return;
			end
			want = expected_beats.pop_front();
			if (ch !== want.ch) begin
				$display("%0t: out_char expected %02h actual %02h", $time, want.ch, ch);
				errors++;
			end
			if (last !== want.last) begin
				$display("%0t: last_of_run expected %0b actual %0b", $time, want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [CHAR_W-1:0]     in_char;
	logic                  out_valid;
	logic                  out_ready;
	logic [CHAR_W-1:0]     out_char;
	logic                  last_of_run;

	detab_scoreboard sb = new();

	bit idling = 1'b1;
	bit hold_armed = 1'b0;
	bit hold_used = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	tab_expand_with_stop_list #(
		.MAX_STOPS    (MAX_STOPS),
		.LINE_COLUMNS (LINE_COLUMNS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_char     (in_char),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.last_of_run (last_of_run)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Output side: check every transfer, then pick ready for the next cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_beat(out_char, last_of_run);
			if (hold_armed && !hold_used) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !idling || ($urandom_range(99) >= 25);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Valid stays high across back-to-back transfers; drop it only for a gap.
	task automatic send_char(logic [CHAR_W-1:0] c);
		if (idling) begin
			while ($urandom_range(99) < 25) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_char <= c;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_char(c);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait for every expected byte, then let the pipeline go quiet.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CHAR_W-1:0] random_char();
		int r;
		r = $urandom_range(99);
		if (r < 30)
			return CH_TAB;
		if (r < 37)
			return CH_NL;
		return CHAR_W'($urandom_range(255));
	endfunction

	task automatic program_setting(int kind);
		logic [CFG_DATA_W-1:0] s;
		case (kind)
		0: begin
			write_reg(REG_STOP_COUNT, 6'h00);
			write_reg(REG_DEFAULT_INTERVAL, 6'h01);
		end
		2: begin
			write_reg(REG_STOP_COUNT, 6'h06);
			write_reg(REG_DEFAULT_INTERVAL, 6'h0F);
		end
		3: begin
			write_reg(REG_STOP_COUNT, 6'h3F);
			write_reg(REG_DEFAULT_INTERVAL, 6'h30);
		end
		default: begin
			write_reg(REG_STOP_COUNT, CFG_DATA_W'($urandom_range(63)));
			write_reg(REG_DEFAULT_INTERVAL, CFG_DATA_W'($urandom_range(63)));
		end
		endcase
		for (int i = 0; i < NUM_STOPS; i++) begin
			case (kind)
			2: s = CFG_DATA_W'(LAST_COL);
			3: s = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom_range(63, 56))
				: CFG_DATA_W'($urandom_range(15));
			default: s = CFG_DATA_W'($urandom_range(63));
			endcase
			write_reg(CFG_IDX_W'(REG_STOP_A + i), s);
		end
	endtask

	initial begin
		int kinds[6];
		kinds = '{0, 1, 2, 1, 3, 1};
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_char = '0;
		out_ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: default stops every eight columns
		send_char(8'h41);
		send_char(CH_TAB);
		send_char(8'h00);
		send_char(8'hFF);
		send_char(CH_TAB);
		send_char(CH_NL);
		send_char(CH_TAB);
		send_char(CH_NL);
		settle();

		// wide interval walks the column into saturation
		write_reg(REG_DEFAULT_INTERVAL, 6'h3F);
		repeat (6) send_char(CH_TAB);
		send_char(8'h7E);
		send_char(8'h78);
		send_char(CH_NL);
		settle();

		// oversized count, zero interval, unordered and duplicate stops, one at the edge
		write_reg(REG_STOP_COUNT, 6'h3F);
		write_reg(REG_DEFAULT_INTERVAL, 6'h30);
		write_reg(REG_STOP_A, 6'd63);
		write_reg(REG_STOP_B, 6'd5);
		write_reg(REG_STOP_C, 6'd20);
		write_reg(REG_STOP_D, 6'd5);
		write_reg(REG_STOP_E, 6'd0);
		write_reg(REG_STOP_F, 6'd40);
		repeat (5) send_char(CH_TAB);
		send_char(CH_NL);
		send_char(8'h71);
		settle();

		for (int p = 0; p < 6; p++) begin
			program_setting(kinds[p]);
			idling = (p != 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 1 && n == 30)
					hold_armed = 1'b1;
				send_char(random_char());
			end
			settle();
		end

		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
